// File: hdl/chroma_key_alpha_blend_macros.svh
// Assertion helpers shared by the chroma key modules.
// Both sample on the rising clock edge and stay quiet while reset is high.
`ifndef CHROMA_KEY_ALPHA_BLEND_MACROS_SVH
`define CHROMA_KEY_ALPHA_BLEND_MACROS_SVH

// Property that holds at every edge.
`define CKAB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Antecedent at one edge, consequent at the next edge.
`define CKAB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/ckab_pkg.sv
`default_nettype none

package ckab_pkg;

   // Q0.16 unity and BT.601 weights
   localparam logic [16:0] Q16_ONE    = 17'd65536;
   localparam logic [15:0] W_YR       = 16'd19595;
   localparam logic [15:0] W_YG       = 16'd38470;
   localparam logic [15:0] W_YB       = 16'd7471;
   localparam logic [15:0] W_U        = 16'd32244;
   localparam logic [15:0] W_V        = 16'd57475;
   localparam logic [16:0] HARD_LIMIT = 17'd6;
   localparam logic [17:0] SMOOTH_K   = 18'd196608;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // un-premultiply divider: 16 quotient bits
   localparam int UDIV_STAGES = 4;
   localparam int UDIV_STEPS  = 4;

   // square root: 18 result digits
   localparam int SQRT_DIGITS = 18;
   localparam int SQRT_STAGES = 9;
   localparam int SQRT_STEPS  = 2;

   // ramp divider: 16 quotient bits
   localparam int RAMP_STAGES = 4;
   localparam int RAMP_STEPS  = 4;

   typedef enum logic [2:0] {
      CSR_KEY_RED,
      CSR_KEY_GREEN,
      CSR_KEY_BLUE,
      CSR_TOLERANCE,
      CSR_SOFTNESS
   } csr_index_type;

   // pixel as it leaves the front end, with its classification
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       zero;   // alpha is zero
      logic [2:0] sat;    // channel at or above alpha: colour is 1.0
   } pixel_type;

   // settings as the back end sees them
   typedef struct packed {
      logic signed [18:0] key_u;
      logic signed [18:0] key_v;
      logic [16:0]        tolerance;
      logic [16:0]        softness;
      logic               hard;
   } cfg_type;

   // Y = (wr r + wg g + wb b) >> 16, colours Q0.16 up to 1.0
   function automatic logic [16:0] luma(input logic [16:0] r, input logic [16:0] g,
                                        input logic [16:0] b);
      logic [32:0] acc;
      acc = 33'(r) * 33'(W_YR) + 33'(g) * 33'(W_YG) + 33'(b) * 33'(W_YB);
      return acc[32:16];
   endfunction

   // floor(w (c - y) / 65536), signed
   function automatic logic signed [18:0] chroma(input logic [16:0] c, input logic [16:0] y,
                                                 input logic [15:0] w);
      logic signed [34:0] dx;
      logic signed [34:0] wx;
      logic signed [34:0] p;
      dx = 35'(signed'({1'b0, c})) - 35'(signed'({1'b0, y}));
      wx = 35'(signed'({1'b0, w}));
      p  = dx * wx;
      return p[34:16];
   endfunction

   // floor(k * 65536 / 255) = 257 k, plus one at full scale
   function automatic logic [16:0] key_level(input logic [7:0] k);
      return {1'b0, k, 8'd0} + 17'(k) + 17'(k == 8'hFF);
   endfunction

endpackage

`default_nettype wire

// File: hdl/ckab_csr.sv
`default_nettype none

module ckab_csr import ckab_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [16:0] csr_data,
   output cfg_type          cfg
);

   logic [7:0]  key_red_ff, key_green_ff, key_blue_ff;
   logic [16:0] tolerance_ff, softness_ff;
   logic [16:0] ky_ff, kr_ff, kb_ff;
   logic signed [18:0] ku_ff, kv_ff;
   logic [16:0] kr_in, kg_in, kb_in;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         key_red_ff   <= 8'd0;
         key_green_ff <= 8'd255;
         key_blue_ff  <= 8'd0;
         tolerance_ff <= 17'd6554;
         softness_ff  <= 17'd6554;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_RED:   key_red_ff   <= csr_data[7:0];
            CSR_KEY_GREEN: key_green_ff <= csr_data[7:0];
            CSR_KEY_BLUE:  key_blue_ff  <= csr_data[7:0];
            CSR_TOLERANCE: tolerance_ff <= csr_data;
            CSR_SOFTNESS:  softness_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // key colour to UV, two stages, running all the time
   assign kr_in = key_level(key_red_ff);
   assign kg_in = key_level(key_green_ff);
   assign kb_in = key_level(key_blue_ff);

   always_ff @(posedge clock) begin
      ky_ff <= luma(kr_in, kg_in, kb_in);
      kr_ff <= kr_in;
      kb_ff <= kb_in;
      ku_ff <= chroma(kb_ff, ky_ff, W_U);
      kv_ff <= chroma(kr_ff, ky_ff, W_V);
   end

   assign cfg.key_u     = ku_ff;
   assign cfg.key_v     = kv_ff;
   assign cfg.tolerance = tolerance_ff;
   assign cfg.softness  = softness_ff;
   assign cfg.hard      = (softness_ff <= HARD_LIMIT);

endmodule

`default_nettype wire

// File: hdl/ckab_front.sv
`default_nettype none
`include "chroma_key_alpha_blend_macros.svh"

module ckab_front import ckab_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_red,
   input  wire logic [7:0] req_in_green,
   input  wire logic [7:0] req_in_blue,
   input  wire logic [7:0] req_in_alpha,
   input  wire logic       pop,
   output pixel_type       head,
   output logic            head_valid
);

   pixel_type             q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  push;
   pixel_type             cls;

   // classify the request
   always_comb begin
      cls.red   = req_in_red;
      cls.green = req_in_green;
      cls.blue  = req_in_blue;
      cls.alpha = req_in_alpha;
      cls.zero  = (req_in_alpha == 8'd0);
      cls.sat   = {req_in_blue >= req_in_alpha, req_in_green >= req_in_alpha,
                   req_in_red >= req_in_alpha};
   end

   assign req_stall  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign head       = q_mem_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cls;
      end
   end

   `CKAB_ASSERT(a_queue_bound, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
   `CKAB_ASSERT_NEXT(a_queue_grow, push && !pop, count_ff == $past(count_ff) + 3'd1, "push lost")

endmodule

`default_nettype wire

// File: hdl/ckab_back.sv
`default_nettype none
`include "chroma_key_alpha_blend_macros.svh"

module ckab_back import ckab_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  cfg_type         cfg,
   input  pixel_type       head,
   input  wire logic       head_valid,
   output logic            pop,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_red,
   output logic [7:0]      rsp_out_green,
   output logic [7:0]      rsp_out_blue,
   output logic [7:0]      rsp_out_alpha
);

   logic en;

   // un-premultiply divider stages
   logic [UDIV_STAGES-1:0] a_vld_ff;
   pixel_type              a_pix_ff [UDIV_STAGES];
   logic [7:0]             a_rem_ff [UDIV_STAGES][3];
   logic [15:0]            a_quo_ff [UDIV_STAGES][3];
   logic [7:0]             a_rem_in [UDIV_STAGES][3];
   logic [15:0]            a_quo_in [UDIV_STAGES][3];

   // colour space stages
   logic               y_vld_ff, uv_vld_ff, d_vld_ff, sq_vld_ff, sm_vld_ff;
   pixel_type          y_pix_ff, uv_pix_ff, d_pix_ff, sq_pix_ff, sm_pix_ff;
   logic [16:0]        y_ff, y_r_ff, y_b_ff;
   logic signed [18:0] u_ff, v_ff, du_ff, dv_ff;
   logic [35:0]        squ_ff, sqv_ff;
   logic [35:0]        sum_ff;
   logic [16:0]        col [3];
   logic signed [37:0] du_sq, dv_sq;

   // square root stages
   logic [SQRT_STAGES-1:0] r_vld_ff;
   pixel_type              r_pix_ff [SQRT_STAGES];
   logic [36:0]            r_x_ff   [SQRT_STAGES];
   logic [36:0]            r_res_ff [SQRT_STAGES];
   logic [36:0]            r_x_in   [SQRT_STAGES];
   logic [36:0]            r_res_in [SQRT_STAGES];

   // band compare
   logic        c_vld_ff, c_below_ff, c_above_ff, c_eq_ff;
   pixel_type   c_pix_ff;
   logic [16:0] c_d_ff;
   logic [17:0] dist_q, band_top, dist_off;

   // ramp divider stages
   logic [RAMP_STAGES-1:0] t_vld_ff, t_below_ff, t_top_ff;
   pixel_type              t_pix_ff [RAMP_STAGES];
   logic [16:0]            t_rem_ff [RAMP_STAGES];
   logic [15:0]            t_quo_ff [RAMP_STAGES];
   logic [16:0]            t_rem_in [RAMP_STAGES];
   logic [15:0]            t_quo_in [RAMP_STAGES];

   // smoothstep and blend
   logic        tt_vld_ff, pp_vld_ff, bl_vld_ff;
   logic        tt_below_ff, pp_below_ff;
   pixel_type   tt_pix_ff, pp_pix_ff, bl_pix_ff;
   logic [32:0] t2_ff;
   logic [17:0] m_ff;
   logic [34:0] hi_ff;
   logic [33:0] lo_ff;
   logic [16:0] blend_ff;
   logic [16:0] ramp;
   logic [33:0] ramp_sq;
   logic [50:0] smooth_acc;
   logic [16:0] blend_in;

   // output register
   logic        rsp_valid_ff;
   logic [7:0]  rsp_red_ff, rsp_green_ff, rsp_blue_ff, rsp_alpha_ff;
   logic [24:0] scaled [4];

   logic [UDIV_STAGES+SQRT_STAGES+RAMP_STAGES+9-1:0] stage_vld;

   // the whole pipe moves whenever the output register can take a result
   assign en  = !rsp_valid_ff || !rsp_stall;
   assign pop = en && head_valid;

   // un-premultiply: floor(ch * 65536 / alpha), four quotient bits per stage
   always_comb begin : udiv_comb
      logic [7:0]  rem;
      logic [15:0] quo;
      logic [8:0]  rx;
      logic [7:0]  dvs;
      for (int s = 0; s < UDIV_STAGES; s++) begin
         for (int l = 0; l < 3; l++) begin
            if (s == 0) begin
               dvs = head.alpha;
               quo = '0;
               case (l)
                  0:       rem = head.red;
                  1:       rem = head.green;
                  default: rem = head.blue;
               endcase
            end else begin
               dvs = a_pix_ff[s-1].alpha;
               rem = a_rem_ff[s-1][l];
               quo = a_quo_ff[s-1][l];
            end
            for (int k = 0; k < UDIV_STEPS; k++) begin
               rx = {rem, 1'b0};
               if (rx >= {1'b0, dvs}) begin
                  rem = 8'(rx - {1'b0, dvs});
                  quo = {quo[14:0], 1'b1};
               end else begin
                  rem = rx[7:0];
                  quo = {quo[14:0], 1'b0};
               end
            end
            a_rem_in[s][l] = rem;
            a_quo_in[s][l] = quo;
         end
      end
   end

   // colour saturated to 1.0 where the channel is not below alpha
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         col[l] = a_pix_ff[UDIV_STAGES-1].sat[l] ? Q16_ONE :
                  {1'b0, a_quo_ff[UDIV_STAGES-1][l]};
      end
      du_sq = 38'(du_ff) * 38'(du_ff);
      dv_sq = 38'(dv_ff) * 38'(dv_ff);
   end

   // integer square root, two result digits per stage
   always_comb begin : sqrt_comb
      logic [36:0] x;
      logic [36:0] res;
      logic [36:0] bitv;
      logic [36:0] trial;
      for (int s = 0; s < SQRT_STAGES; s++) begin
         if (s == 0) begin
            x   = {1'b0, sum_ff};
            res = '0;
         end else begin
            x   = r_x_ff[s-1];
            res = r_res_ff[s-1];
         end
         for (int k = 0; k < SQRT_STEPS; k++) begin
            bitv  = 37'(1) << (2 * (SQRT_DIGITS - 1 - (s * SQRT_STEPS + k)));
            trial = res + bitv;
            if (x >= trial) begin
               x   = x - trial;
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
         end
         r_x_in[s]   = x;
         r_res_in[s] = res;
      end
   end

   // where the distance falls against the soft band
   assign dist_q   = r_res_ff[SQRT_STAGES-1][17:0];
   assign band_top = {1'b0, cfg.tolerance} + {1'b0, cfg.softness};
   assign dist_off = dist_q - {1'b0, cfg.tolerance};

   // ramp: floor(d * 65536 / softness), four quotient bits per stage
   always_comb begin : ramp_comb
      logic [16:0] rem;
      logic [15:0] quo;
      logic [17:0] rx;
      for (int s = 0; s < RAMP_STAGES; s++) begin
         if (s == 0) begin
            rem = c_d_ff;
            quo = '0;
         end else begin
            rem = t_rem_ff[s-1];
            quo = t_quo_ff[s-1];
         end
         for (int k = 0; k < RAMP_STEPS; k++) begin
            rx = {rem, 1'b0};
            if (rx >= {1'b0, cfg.softness}) begin
               rem = 17'(rx - {1'b0, cfg.softness});
               quo = {quo[14:0], 1'b1};
            end else begin
               rem = rx[16:0];
               quo = {quo[14:0], 1'b0};
            end
         end
         t_rem_in[s] = rem;
         t_quo_in[s] = quo;
      end
   end

   // smoothstep from the ramp, hard mode overrides; channels scaled by the blend
   always_comb begin
      if (t_below_ff[RAMP_STAGES-1]) begin
         ramp = '0;
      end else if (t_top_ff[RAMP_STAGES-1]) begin
         ramp = Q16_ONE;
      end else begin
         ramp = {1'b0, t_quo_ff[RAMP_STAGES-1]};
      end
      ramp_sq    = 34'(ramp) * 34'(ramp);
      smooth_acc = {hi_ff, 16'd0} + 51'(lo_ff);
      if (cfg.hard) begin
         blend_in = pp_below_ff ? 17'd0 : Q16_ONE;
      end else begin
         blend_in = smooth_acc[48:32];
      end
      scaled[0] = 25'(bl_pix_ff.red) * 25'(blend_ff);
      scaled[1] = 25'(bl_pix_ff.green) * 25'(blend_ff);
      scaled[2] = 25'(bl_pix_ff.blue) * 25'(blend_ff);
      scaled[3] = 25'(bl_pix_ff.alpha) * 25'(blend_ff);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= '0;
         y_vld_ff     <= 1'b0;
         uv_vld_ff    <= 1'b0;
         d_vld_ff     <= 1'b0;
         sq_vld_ff    <= 1'b0;
         sm_vld_ff    <= 1'b0;
         r_vld_ff     <= '0;
         c_vld_ff     <= 1'b0;
         t_vld_ff     <= '0;
         tt_vld_ff    <= 1'b0;
         pp_vld_ff    <= 1'b0;
         bl_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff     <= {a_vld_ff[UDIV_STAGES-2:0], head_valid};
         y_vld_ff     <= a_vld_ff[UDIV_STAGES-1];
         uv_vld_ff    <= y_vld_ff;
         d_vld_ff     <= uv_vld_ff;
         sq_vld_ff    <= d_vld_ff;
         sm_vld_ff    <= sq_vld_ff;
         r_vld_ff     <= {r_vld_ff[SQRT_STAGES-2:0], sm_vld_ff};
         c_vld_ff     <= r_vld_ff[SQRT_STAGES-1];
         t_vld_ff     <= {t_vld_ff[RAMP_STAGES-2:0], c_vld_ff};
         tt_vld_ff    <= t_vld_ff[RAMP_STAGES-1];
         pp_vld_ff    <= tt_vld_ff;
         bl_vld_ff    <= pp_vld_ff;
         rsp_valid_ff <= bl_vld_ff;
      end
   end

   // data path
   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < UDIV_STAGES; s++) begin
            a_pix_ff[s] <= (s == 0) ? head : a_pix_ff[(s == 0) ? 0 : s-1];
            for (int l = 0; l < 3; l++) begin
               a_rem_ff[s][l] <= a_rem_in[s][l];
               a_quo_ff[s][l] <= a_quo_in[s][l];
            end
         end

         y_pix_ff  <= a_pix_ff[UDIV_STAGES-1];
         y_ff      <= luma(col[0], col[1], col[2]);
         y_r_ff    <= col[0];
         y_b_ff    <= col[2];

         uv_pix_ff <= y_pix_ff;
         u_ff      <= chroma(y_b_ff, y_ff, W_U);
         v_ff      <= chroma(y_r_ff, y_ff, W_V);

         d_pix_ff  <= uv_pix_ff;
         du_ff     <= u_ff - cfg.key_u;
         dv_ff     <= v_ff - cfg.key_v;

         sq_pix_ff <= d_pix_ff;
         squ_ff    <= du_sq[35:0];
         sqv_ff    <= dv_sq[35:0];

         sm_pix_ff <= sq_pix_ff;
         sum_ff    <= squ_ff + sqv_ff;

         for (int s = 0; s < SQRT_STAGES; s++) begin
            r_pix_ff[s] <= (s == 0) ? sm_pix_ff : r_pix_ff[(s == 0) ? 0 : s-1];
            r_x_ff[s]   <= r_x_in[s];
            r_res_ff[s] <= r_res_in[s];
         end

         c_pix_ff   <= r_pix_ff[SQRT_STAGES-1];
         c_below_ff <= (dist_q < {1'b0, cfg.tolerance});
         c_above_ff <= (dist_q > band_top);
         c_d_ff     <= dist_off[16:0];
         c_eq_ff    <= (dist_off[16:0] == cfg.softness);

         for (int s = 0; s < RAMP_STAGES; s++) begin
            t_pix_ff[s] <= (s == 0) ? c_pix_ff : t_pix_ff[(s == 0) ? 0 : s-1];
            t_rem_ff[s] <= t_rem_in[s];
            t_quo_ff[s] <= t_quo_in[s];
         end
         t_below_ff <= {t_below_ff[RAMP_STAGES-2:0], c_below_ff};
         t_top_ff   <= {t_top_ff[RAMP_STAGES-2:0], c_above_ff || c_eq_ff};

         tt_pix_ff   <= t_pix_ff[RAMP_STAGES-1];
         tt_below_ff <= t_below_ff[RAMP_STAGES-1];
         t2_ff       <= ramp_sq[32:0];
         m_ff        <= SMOOTH_K - {ramp, 1'b0};

         pp_pix_ff   <= tt_pix_ff;
         pp_below_ff <= tt_below_ff;
         hi_ff       <= 35'(t2_ff[32:16]) * 35'(m_ff);
         lo_ff       <= 34'(t2_ff[15:0]) * 34'(m_ff);

         bl_pix_ff   <= pp_pix_ff;
         blend_ff    <= blend_in;

         rsp_red_ff   <= bl_pix_ff.zero ? 8'd0 : scaled[0][23:16];
         rsp_green_ff <= bl_pix_ff.zero ? 8'd0 : scaled[1][23:16];
         rsp_blue_ff  <= bl_pix_ff.zero ? 8'd0 : scaled[2][23:16];
         rsp_alpha_ff <= bl_pix_ff.zero ? 8'd0 : scaled[3][23:16];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue  = rsp_blue_ff;
   assign rsp_out_alpha = rsp_alpha_ff;

   assign stage_vld = {a_vld_ff, y_vld_ff, uv_vld_ff, d_vld_ff, sq_vld_ff, sm_vld_ff,
                       r_vld_ff, c_vld_ff, t_vld_ff, tt_vld_ff, pp_vld_ff, bl_vld_ff};

   `CKAB_ASSERT_NEXT(a_pipe_hold, !en, $stable(stage_vld), "pipe moved while held")
   `CKAB_ASSERT(a_blend_max, bl_vld_ff |-> blend_ff <= Q16_ONE, "blend above one")
   `CKAB_ASSERT(a_hard_blend, (bl_vld_ff && cfg.hard) |-> (blend_ff == 17'd0 || blend_ff == Q16_ONE), "hard blend not binary")

endmodule

`default_nettype wire

// File: hdl/chroma_key_alpha_blend.sv
`default_nettype none

// Chroma key with soft edge for premultiplied RGBA8 pixels. A request carries one
// pixel; the response carries the four channels scaled by the key blend and
// truncated, zero where alpha is zero. The block takes one pixel per clock while
// the response is not stalled. The pipeline contains two pipelined dividers
// (un-premultiply and ramp, four quotient bits a stage) and the pipelined square
// root (two digits a stage). A four-entry queue sits between the request side and
// the pipeline, and the pipeline holds in place while the response is stalled.
// The user must write registers through the csr port only while no pixel is in
// flight; the block itself does not enforce this. Key colour changes pass
// through the luma and UV registers before they reach the compare.

module chroma_key_alpha_blend import ckab_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [16:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_red,
   input  wire logic [7:0]  req_in_green,
   input  wire logic [7:0]  req_in_blue,
   input  wire logic [7:0]  req_in_alpha,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_red,
   output logic [7:0]       rsp_out_green,
   output logic [7:0]       rsp_out_blue,
   output logic [7:0]       rsp_out_alpha
);

   cfg_type   cfg;
   pixel_type head;
   logic      head_valid;
   logic      pop;

   ckab_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ckab_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_red   (req_in_red),
      .req_in_green (req_in_green),
      .req_in_blue  (req_in_blue),
      .req_in_alpha (req_in_alpha),
      .pop          (pop),
      .head         (head),
      .head_valid   (head_valid)
   );

   ckab_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .head          (head),
      .head_valid    (head_valid),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_alpha (rsp_out_alpha)
   );

endmodule

`default_nettype wire

// File: tb/tb_chroma_key_alpha_blend.sv
`timescale 1ns / 1ps

import ckab_pkg::*;

// expected output pixel
typedef struct {
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
} rgba_type;

// Tracks the key settings and predicts blended pixels in request order
class blend_scoreboard;
   logic [7:0]  key_r = 8'd0;
   logic [7:0]  key_g = 8'd255;
   logic [7:0]  key_b = 8'd0;
   logic [16:0] tol   = 17'd6554;
   logic [16:0] band  = 17'd6554;
   rgba_type    pending_pixels[$];
   int          errors = 0;

   function void set_reg(logic [2:0] idx, logic [16:0] data);
      case (idx)
         CSR_KEY_RED:   key_r = data[7:0];
         CSR_KEY_GREEN: key_g = data[7:0];
         CSR_KEY_BLUE:  key_b = data[7:0];
         CSR_TOLERANCE: tol   = data;
         CSR_SOFTNESS:  band  = data;
         default: ;
      endcase
   endfunction

   function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // BT.601 U and V from Q0.16 colour
   function void colour_uv(longint r, longint g, longint b, output longint u, output longint v);
      longint y;
      y = (19595 * r + 38470 * g + 7471 * b) >>> 16;
      u = (32244 * (b - y)) >>> 16;
      v = (57475 * (r - y)) >>> 16;
   endfunction

   function longint unpremul(longint ch, longint a);
      longint c;
      c = (ch * 65536) / a;
      return (c > 65536) ? 65536 : c;
   endfunction

   function void note_request(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
      rgba_type        px;
      longint          u, v, ku, kv, du, dv;
      longint unsigned dist_val, t, blend;
      if (a == 0) begin
         px = '{8'd0, 8'd0, 8'd0, 8'd0};
      end else begin
         colour_uv(unpremul(r, a), unpremul(g, a), unpremul(b, a), u, v);
         colour_uv((longint'(key_r) * 65536) / 255, (longint'(key_g) * 65536) / 255,
                   (longint'(key_b) * 65536) / 255, ku, kv);
         du       = u - ku;
         dv       = v - kv;
         dist_val = int_sqrt(du * du + dv * dv);
         if (band <= 6) begin
            blend = (dist_val < tol) ? 0 : 65536;
         end else begin
            if (dist_val < tol) t = 0;
            else if (dist_val > tol + band) t = 65536;
            else t = ((dist_val - tol) * 65536) / band;
            blend = (t * t * (196608 - 2 * t)) >> 32;
         end
         px.red   = 8'((longint'(r) * blend) >> 16);
         px.green = 8'((longint'(g) * blend) >> 16);
         px.blue  = 8'((longint'(b) * blend) >> 16);
         px.alpha = 8'((longint'(a) * blend) >> 16);
      end
      pending_pixels.push_back(px);
   endfunction

   function void check_response(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
      rgba_type px;
      if (pending_pixels.size() == 0) begin
         $error("response with no request outstanding");
         errors++;
         return;
      end
      px = pending_pixels.pop_front();
      if (r !== px.red) begin
         $error("out_red expected %0d actual %0d", px.red, r);
         errors++;
      end
      if (g !== px.green) begin
         $error("out_green expected %0d actual %0d", px.green, g);
         errors++;
      end
      if (b !== px.blue) begin
         $error("out_blue expected %0d actual %0d", px.blue, b);
         errors++;
      end
      if (a !== px.alpha) begin
         $error("out_alpha expected %0d actual %0d", px.alpha, a);
         errors++;
      end
   endfunction
endclass

module tb_chroma_key_alpha_blend;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [16:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_red = '0;
   logic [7:0]  req_in_green = '0;
   logic [7:0]  req_in_blue = '0;
   logic [7:0]  req_in_alpha = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic [7:0]  rsp_out_alpha;

   blend_scoreboard sb = new();
   logic [31:0]     pixel_queue[$];   // {r, g, b, a} waiting to be sent
   bit              no_idle = 1'b0;
   bit              hold_off = 1'b0;
   int              quiet_cycles = 0;

   chroma_key_alpha_blend dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // request driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_in_red, req_in_green, req_in_blue, req_in_alpha);
            void'(pixel_queue.pop_front());
         end
         if (req_valid && req_stall) begin
            // held until taken
         end else if (pixel_queue.size() > 0 && !hold_off &&
                      (no_idle || $urandom_range(99) >= 7)) begin
            req_valid <= 1'b1;
            {req_in_red, req_in_green, req_in_blue, req_in_alpha} <= pixel_queue[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha);
         rsp_stall <= !no_idle && ($urandom_range(99) < 7);
      end
   end

   // watchdog on stalled progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 3000) begin
         $display("tb_chroma_key_alpha_blend: errors");
         $finish;
      end
   end

   task automatic csr_put(logic [2:0] idx, logic [16:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      sb.set_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic csr_setup(logic [7:0] kr, logic [7:0] kg, logic [7:0] kb,
                            logic [16:0] tl, logic [16:0] sf);
      csr_put(CSR_KEY_RED, {9'd0, kr});
      csr_put(CSR_KEY_GREEN, {9'd0, kg});
      csr_put(CSR_KEY_BLUE, {9'd0, kb});
      csr_put(CSR_TOLERANCE, tl);
      csr_put(CSR_SOFTNESS, sf);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pixel_queue.size() > 0 || req_valid || sb.pending_pixels.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
      pixel_queue.push_back({r, g, b, a});
   endtask

   // mostly valid premultiplied pixels, many near the key colour
   task automatic queue_random(int count);
      int          kind;
      int          cr, cg, cb, ca;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(99);
         ca   = (kind < 60) ? $urandom_range(1, 255) : 255;
         if (kind < 45) begin
            cr = int'(sb.key_r) + $urandom_range(40) - 20;
            cg = int'(sb.key_g) + $urandom_range(40) - 20;
            cb = int'(sb.key_b) + $urandom_range(40) - 20;
         end else begin
            cr = $urandom_range(255);
            cg = $urandom_range(255);
            cb = $urandom_range(255);
         end
         cr = (cr < 0) ? 0 : (cr > 255) ? 255 : cr;
         cg = (cg < 0) ? 0 : (cg > 255) ? 255 : cg;
         cb = (cb < 0) ? 0 : (cb > 255) ? 255 : cb;
         if (kind >= 90)
            queue_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom));   // raw, may exceed alpha
         else if (kind >= 85)
            queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'd0);
         else
            queue_pixel(8'(cr * ca / 255), 8'(cg * ca / 255), 8'(cb * ca / 255), 8'(ca));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset key settings, extremes and special cases
      queue_pixel(8'd0, 8'd255, 8'd0, 8'd255);     // exactly the key
      queue_pixel(8'd255, 8'd0, 8'd255, 8'd255);
      queue_pixel(8'd255, 8'd255, 8'd255, 8'd0);   // zero alpha
      queue_pixel(8'd0, 8'd0, 8'd0, 8'd0);
      queue_pixel(8'd200, 8'd10, 8'd250, 8'd5);    // channels above alpha
      queue_pixel(8'd1, 8'd1, 8'd1, 8'd1);
      queue_pixel(8'd255, 8'd255, 8'd255, 8'd255);
      queue_pixel(8'd0, 8'd0, 8'd0, 8'd255);
      queue_pixel(8'd20, 8'd220, 8'd30, 8'd255);   // inside the soft band
      queue_pixel(8'd40, 8'd200, 8'd40, 8'd255);
      queue_pixel(8'd10, 8'd120, 8'd12, 8'd128);
      drain();

      // out-of-range index is ignored; wide data is masked
      csr_put(3'd5, 17'h1FFFF);
      csr_put(3'd7, 17'h1FFFF);
      csr_put(CSR_KEY_RED, 17'h1FF00);
      csr_write <= 1'b0;
      @(posedge clock);
      queue_pixel(8'd0, 8'd255, 8'd0, 8'd255);
      queue_pixel(8'd90, 8'd160, 8'd70, 8'd255);
      drain();

      // hard threshold at tolerance zero and at the limit
      csr_setup(8'd0, 8'd0, 8'd255, 17'd0, 17'd0);
      queue_pixel(8'd0, 8'd0, 8'd255, 8'd255);
      queue_pixel(8'd0, 8'd0, 8'd200, 8'd200);
      queue_random(200);
      drain();

      csr_setup(8'd0, 8'd255, 8'd0, 17'd6554, 17'd6);
      queue_random(250);
      drain();

      csr_setup(8'd0, 8'd255, 8'd0, 17'd6554, 17'd7);
      queue_random(250);
      drain();

      csr_setup(8'd255, 8'd255, 8'd255, 17'd65536, 17'd65536);
      queue_random(250);
      drain();

      csr_setup(8'd255, 8'd0, 8'd0, 17'h1FFFF, 17'h1FFFF);
      queue_random(200);
      drain();

      // stretch with no idling on either side, with a pause to empty the pipe
      no_idle = 1'b1;
      csr_setup(8'd30, 8'd200, 8'd60, 17'd3000, 17'd20000);
      queue_random(150);
      while (pixel_queue.size() > 75) @(posedge clock);
      hold_off = 1'b1;
      while (req_valid || sb.pending_pixels.size() > 0) @(posedge clock);
      hold_off = 1'b0;
      drain();
      no_idle = 1'b0;

      for (int p = 0; p < 4; p++) begin
         csr_setup(8'($urandom), 8'($urandom), 8'($urandom), 17'($urandom_range(40000)),
                   17'($urandom_range(65536)));
         queue_random(200);
         drain();
      end

      if (sb.errors == 0 && sb.pending_pixels.size() == 0)
         $display("tb_chroma_key_alpha_blend: clean");
      else
         $display("tb_chroma_key_alpha_blend: errors");
      $finish;
   end
endmodule
